// ===== rtl/core/tts_pkg.sv =====
// Package for the triangle tangent stream core.
// Holds the item structs, the field and datapath widths and the serial step counts.
// Depends on nothing; every other file of the core uses it.
package tts_pkg;

    localparam int PosW = 16;
    localparam int TexW = 16;
    localparam int TanW = 32;

    // Edges and UV deltas are exact differences of two 16-bit values.
    localparam int EdgeW = 17;
    // Determinant and numerators are sums of two 17x17 products.
    localparam int AccW = 36;
    // Magnitude of a determinant or numerator.
    localparam int MagW = 34;
    // Bits of the scaled quotient before rounding, and the scale of the dividend.
    localparam int QuoW = 33;
    localparam int ScaleShift = 21;
    localparam int LowBits = QuoW - ScaleShift;
    // Rounded quotient.
    localparam int RndW = QuoW;

    // One determinant lane and three numerator lanes.
    localparam int NumLanes = 4;
    localparam int NumComps = 3;

    localparam int MulSteps = EdgeW;
    localparam int DivSteps = QuoW;
    localparam int CntW = $clog2(DivSteps);

    localparam int CornersPerTri = 3;
    localparam logic [1:0] LastCorner = 2'(CornersPerTri - 1);

    localparam logic signed [TanW-1:0] TanMax = {1'b0, {(TanW-1){1'b1}}};
    localparam logic signed [TanW-1:0] TanMin = {1'b1, {(TanW-1){1'b0}}};

    typedef struct packed {
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
        logic signed [TexW-1:0] tex_u;
        logic signed [TexW-1:0] tex_v;
    } t_vtx;

    typedef struct packed {
        logic signed [TanW-1:0] tan_x;
        logic signed [TanW-1:0] tan_y;
        logic signed [TanW-1:0] tan_z;
        logic                   degenerate;
    } t_tan;

endpackage

// ===== rtl/core/tts_stream_if.sv =====
// Stream interfaces of the triangle tangent stream core.
// One interface for vertex items and one for tangent items, each with valid and ready.
// Depends on tts_pkg for the payload structs.
interface tts_vtx_if;
    logic          valid;
    logic          ready;
    tts_pkg::t_vtx data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tts_tan_if;
    logic          valid;
    logic          ready;
    tts_pkg::t_tan data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/triangle_tangent_stream_core.sv =====
// Top level of the triangle tangent stream core: corner store, bit-serial multiply and divide.
// Depends on tts_pkg and on the interfaces in tts_stream_if.sv.
//
//   channel  direction  item     payload
//   i_vtx    in         vertex   pos_x pos_y pos_z (Q8.8), tex_u tex_v (Q4.12)
//   o_tan    out        tangent  tan_x tan_y tan_z (Q16.16), degenerate
//
// The first two corners of a triangle are stored and give no item.
// The third corner starts the shared bit-serial multiply of the two UV deltas, then the
// three radix-2 dividers running side by side, with set-up before and rounding after;
// a zero determinant skips the divide. The multiply and divide steps set the rate.
// A finished tangent waits in the output register while the next corners are stored.
// Reset is synchronous and active low and clears only control state.
module triangle_tangent_stream_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tts_vtx_if.sink       i_vtx,
    tts_tan_if.source     o_tan
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ABS  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_RND  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [1:0]                    r_corner;
    logic [tts_pkg::CntW-1:0]      r_cnt;
    logic                          r_ovalid;
    tts_pkg::t_tan                 r_odata;

    logic signed [tts_pkg::PosW-1:0] r_p0 [tts_pkg::NumComps];
    logic signed [tts_pkg::PosW-1:0] r_p1 [tts_pkg::NumComps];
    logic signed [tts_pkg::TexW-1:0] r_t0 [2];
    logic signed [tts_pkg::TexW-1:0] r_t1 [2];

    logic signed [tts_pkg::EdgeW-1:0] r_ma [tts_pkg::NumLanes];
    logic signed [tts_pkg::EdgeW-1:0] r_mc [tts_pkg::NumLanes];
    logic signed [tts_pkg::EdgeW-1:0] r_mb2;
    logic signed [tts_pkg::EdgeW-1:0] r_mb1;
    logic signed [tts_pkg::AccW-1:0]  r_acc [tts_pkg::NumLanes];

    logic [tts_pkg::MagW-1:0] r_ad;
    logic [tts_pkg::MagW-1:0] r_an  [tts_pkg::NumComps];
    logic                     r_neg [tts_pkg::NumComps];
    logic                     r_ovf [tts_pkg::NumComps];
    logic [tts_pkg::MagW-1:0] r_rem [tts_pkg::NumComps];
    logic [tts_pkg::QuoW-1:0] r_dsh [tts_pkg::NumComps];
    logic [tts_pkg::RndW-1:0] r_q   [tts_pkg::NumComps];
    logic                     r_degen;

    logic signed [tts_pkg::PosW-1:0] in_pos [tts_pkg::NumComps];
    logic                            vtx_fire;
    logic                            last_corner;
    logic                            mul_last;
    logic                            div_last;
    logic                            det_zero;
    logic                            out_load;
    logic signed [tts_pkg::TanW-1:0] tan_val [tts_pkg::NumComps];

    function automatic logic signed [tts_pkg::EdgeW-1:0] diff16(
        input logic signed [15:0] a,
        input logic signed [15:0] b
    );
        return {a[15], a} - {b[15], b};
    endfunction

    function automatic logic signed [tts_pkg::AccW-1:0] sext_edge(
        input logic signed [tts_pkg::EdgeW-1:0] a
    );
        return {{(tts_pkg::AccW - tts_pkg::EdgeW){a[tts_pkg::EdgeW-1]}}, a};
    endfunction

    function automatic logic [tts_pkg::MagW-1:0] mag(
        input logic signed [tts_pkg::AccW-1:0] a
    );
        logic signed [tts_pkg::AccW-1:0] m;
        m = a[tts_pkg::AccW-1] ? -a : a;
        return m[tts_pkg::MagW-1:0];
    endfunction

    assign in_pos[0] = i_vtx.data.pos_x;
    assign in_pos[1] = i_vtx.data.pos_y;
    assign in_pos[2] = i_vtx.data.pos_z;

    assign i_vtx.ready = (r_state == S_IDLE);
    assign vtx_fire    = i_vtx.valid && i_vtx.ready;
    assign last_corner = (r_corner == tts_pkg::LastCorner);
    assign mul_last    = (r_cnt == tts_pkg::CntW'(tts_pkg::MulSteps - 1));
    assign div_last    = (r_cnt == tts_pkg::CntW'(tts_pkg::DivSteps - 1));
    assign det_zero    = (r_acc[0] == '0);
    assign out_load    = (r_state == S_OUT) && (!r_ovalid || o_tan.ready);

    assign o_tan.valid = r_ovalid;
    assign o_tan.data  = r_odata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (vtx_fire && last_corner) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_last) begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                n_state = det_zero ? S_OUT : S_CHK;
            end
            S_CHK: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_last) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_corner <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (vtx_fire) begin
                r_corner <= last_corner ? 2'd0 : r_corner + 2'd1;
            end
            if ((r_state == S_MUL && !mul_last) || (r_state == S_DIV && !div_last)) begin
                r_cnt <= r_cnt + tts_pkg::CntW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_tan.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < tts_pkg::NumComps; k++) begin
            if (r_neg[k]) begin
                if (r_ovf[k] || r_q[k][tts_pkg::RndW-1]
                        || (r_q[k][tts_pkg::TanW-1] && (|r_q[k][tts_pkg::TanW-2:0]))) begin
                    tan_val[k] = tts_pkg::TanMin;
                end else begin
                    tan_val[k] = -$signed(r_q[k][tts_pkg::TanW-1:0]);
                end
            end else begin
                if (r_ovf[k] || r_q[k][tts_pkg::RndW-1] || r_q[k][tts_pkg::TanW-1]) begin
                    tan_val[k] = tts_pkg::TanMax;
                end else begin
                    tan_val[k] = $signed(r_q[k][tts_pkg::TanW-1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (vtx_fire) begin
                    r_degen <= 1'b0;
                    if (r_corner == 2'd0) begin
                        for (int k = 0; k < tts_pkg::NumComps; k++) begin
                            r_p0[k] <= in_pos[k];
                        end
                        r_t0[0] <= i_vtx.data.tex_u;
                        r_t0[1] <= i_vtx.data.tex_v;
                    end else if (!last_corner) begin
                        for (int k = 0; k < tts_pkg::NumComps; k++) begin
                            r_p1[k] <= in_pos[k];
                        end
                        r_t1[0] <= i_vtx.data.tex_u;
                        r_t1[1] <= i_vtx.data.tex_v;
                    end else begin
                        r_ma[0] <= diff16(r_t1[0], r_t0[0]);
                        r_mc[0] <= diff16(i_vtx.data.tex_u, r_t0[0]);
                        for (int k = 0; k < tts_pkg::NumComps; k++) begin
                            r_ma[k+1] <= diff16(r_p1[k], r_p0[k]);
                            r_mc[k+1] <= diff16(in_pos[k], r_p0[k]);
                        end
                        r_mb1 <= diff16(r_t1[1], r_t0[1]);
                        r_mb2 <= diff16(i_vtx.data.tex_v, r_t0[1]);
                    end
                end
            end
            S_MUL: begin
                for (int l = 0; l < tts_pkg::NumLanes; l++) begin
                    if (r_cnt == '0) begin
                        r_acc[l] <= (r_mb1[tts_pkg::EdgeW-1] ? sext_edge(r_mc[l]) : '0)
                                  - (r_mb2[tts_pkg::EdgeW-1] ? sext_edge(r_ma[l]) : '0);
                    end else begin
                        r_acc[l] <= (r_acc[l] <<< 1)
                                  + (r_mb2[tts_pkg::EdgeW-1] ? sext_edge(r_ma[l]) : '0)
                                  - (r_mb1[tts_pkg::EdgeW-1] ? sext_edge(r_mc[l]) : '0);
                    end
                end
                r_mb2 <= r_mb2 <<< 1;
                r_mb1 <= r_mb1 <<< 1;
            end
            S_ABS: begin
                r_degen <= det_zero;
                r_ad    <= mag(r_acc[0]);
                for (int k = 0; k < tts_pkg::NumComps; k++) begin
                    r_an[k]  <= mag(r_acc[k+1]);
                    r_neg[k] <= r_acc[k+1][tts_pkg::AccW-1] ^ r_acc[0][tts_pkg::AccW-1];
                end
            end
            S_CHK: begin
                for (int k = 0; k < tts_pkg::NumComps; k++) begin
                    r_ovf[k] <= {{tts_pkg::LowBits{1'b0}}, r_an[k]}
                             >= {r_ad, {tts_pkg::LowBits{1'b0}}};
                    r_rem[k] <= r_an[k] >> tts_pkg::LowBits;
                    r_dsh[k] <= {r_an[k][tts_pkg::LowBits-1:0], {tts_pkg::ScaleShift{1'b0}}};
                end
            end
            S_DIV: begin
                for (int k = 0; k < tts_pkg::NumComps; k++) begin
                    if ({r_rem[k], r_dsh[k][tts_pkg::QuoW-1]} >= {1'b0, r_ad}) begin
                        r_rem[k] <= tts_pkg::MagW'({r_rem[k], r_dsh[k][tts_pkg::QuoW-1]}
                                                   - {1'b0, r_ad});
                        r_dsh[k] <= {r_dsh[k][tts_pkg::QuoW-2:0], 1'b1};
                    end else begin
                        r_rem[k] <= {r_rem[k][tts_pkg::MagW-2:0], r_dsh[k][tts_pkg::QuoW-1]};
                        r_dsh[k] <= {r_dsh[k][tts_pkg::QuoW-2:0], 1'b0};
                    end
                end
            end
            S_RND: begin
                for (int k = 0; k < tts_pkg::NumComps; k++) begin
                    r_q[k] <= tts_pkg::RndW'(({1'b0, r_dsh[k]}
                                              + {{tts_pkg::QuoW{1'b0}}, 1'b1}) >> 1);
                end
            end
            S_OUT: begin
                if (out_load) begin
                    if (r_degen) begin
                        r_odata.tan_x <= '0;
                        r_odata.tan_y <= '0;
                        r_odata.tan_z <= '0;
                    end else begin
                        r_odata.tan_x <= tan_val[0];
                        r_odata.tan_y <= tan_val[1];
                        r_odata.tan_z <= tan_val[2];
                    end
                    r_odata.degenerate <= r_degen;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
